// ----- rtl/lcd4_pkg.sv -----
// Shared types and constants for the 4-bit character LCD interface unit.
package lcd4_pkg;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_WAIT,
    PH_SU_A,
    PH_SU_B,
    PH_P0,
    PH_P1,
    PH_P2,
    PH_P3,
    PH_HI_A,
    PH_HI_B,
    PH_LO_A,
    PH_LO_B
  } phase_t;

  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_CMD    = 3'd1,
    OP_DATA   = 3'd2,
    OP_CURSOR = 3'd3,
    OP_CLEAR  = 3'd4
  } op_t;

  localparam logic [3:0] STEP_SHORT_WAIT = 4'd4;
  localparam logic [3:0] STEP_NIBBLE_TWO = 4'd6;
  localparam logic [3:0] STEP_FIRST_CMD  = 4'd7;
  localparam logic [3:0] STEP_DONE       = 4'd11;

  localparam logic [6:0] SHORT_WAIT_US = 7'd10;

  localparam logic [7:0] CMD_FUNC_SET  = 8'h28;
  localparam logic [7:0] CMD_DISP_ON   = 8'h0C;
  localparam logic [7:0] CMD_ENTRY     = 8'h06;
  localparam logic [7:0] CMD_HOME_ADDR = 8'h80;
  localparam logic [7:0] CMD_CLEAR     = 8'h01;
  localparam logic [7:0] ROW_OFFSET    = 8'h40;

  localparam logic [3:0] NIB_WAKE  = 4'h3;
  localparam logic [3:0] NIB_4BIT  = 4'h2;

  // Start-up command list, indexed by step minus the first command step.
  function automatic logic [7:0] init_cmd(input logic [1:0] idx);
    case (idx)
      2'd0:    init_cmd = CMD_FUNC_SET;
      2'd1:    init_cmd = CMD_DISP_ON;
      2'd2:    init_cmd = CMD_ENTRY;
      default: init_cmd = CMD_HOME_ADDR;
    endcase
  endfunction

endpackage

// ----- rtl/char_lcd_4bit_interface_unit.sv -----
// Top level of the 4-bit character LCD interface unit.
//
// Usage: every input word is one microsecond tick of the LCD sequencer. It
// carries an optional request (command byte, data byte, cursor move, clear)
// and the data lines DB7..DB4 sampled during that tick. Each accepted word
// yields exactly one result word with the levels of E, RS, RW, the driven
// nibble, the bus direction, and the ready/accepted status for that tick.
// The result word is registered and shows in the cycle after the
// input word is accepted. Throughput: one word per cycle while the receiver
// takes results; the state update is a single pass of combinational logic
// between the accepted word and the state and result registers.
// Reset (rst_n low, synchronous) restarts the power-up script: a long
// wait, the wake-up nibbles, then function set, display on, entry mode and
// home address; requests during that script return accepted low.
// Before each byte the busy flag is polled (four ticks per poll, repeated
// while busy); the byte then takes four more ticks.
// When the receiver stalls, the result word is held in the output register
// and in_ready drops until it is taken; no state advances meanwhile.
module char_lcd_4bit_interface_unit #(
  parameter int unsigned LONG_WAIT_US = 100
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_operation,
  input  logic [7:0] in_byte_value,
  input  logic [5:0] in_column,
  input  logic       in_row,
  input  logic [3:0] in_bus_in,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_pin_enable,
  output logic       out_pin_register_select,
  output logic       out_pin_read_write,
  output logic [3:0] out_bus_out,
  output logic       out_bus_drive,
  output logic       out_ready_res,
  output logic       out_accepted
);
  import lcd4_pkg::*;

  localparam logic [6:0] LongWait = 7'(LONG_WAIT_US);

  // Sequencer state
  phase_t     phase_r,        phase_nxt;
  logic [6:0] wait_count_r,   wait_count_nxt;
  logic [3:0] startup_step_r, startup_step_nxt;
  logic [7:0] pending_byte_r, pending_byte_nxt;
  logic       pending_sel_r,  pending_sel_nxt;
  logic       follow_home_r,  follow_home_nxt;
  logic [3:0] status_high_r,  status_high_nxt;
  // Held line levels: RS, RW, bus nibble
  logic       lvl_rs_r;
  logic       lvl_rw_r;
  logic [3:0] lvl_bus_r;

  // Result register
  logic       out_valid_r;
  logic       e_r, rs_r, rw_r, drive_r, rdy_r, acc_r;
  logic [3:0] bus_r;

  // Combinational results of this tick
  logic       e_c, rs_c, rw_c, drive_c, rdy_c, acc_c;
  logic [3:0] bus_c;
  logic       script_adv;
  logic       accept;
  logic [7:0] cursor_addr;

  // Take a new word whenever the result slot is free or being emptied.
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  assign cursor_addr = CMD_HOME_ADDR |
                       (({7'd0, in_row} * ROW_OFFSET) + {2'b00, in_column});

  always_comb begin
    phase_nxt        = phase_r;
    wait_count_nxt   = wait_count_r;
    startup_step_nxt = startup_step_r;
    pending_byte_nxt = pending_byte_r;
    pending_sel_nxt  = pending_sel_r;
    follow_home_nxt  = follow_home_r;
    status_high_nxt  = status_high_r;
    script_adv       = 1'b0;

    rdy_c = (phase_r == PH_IDLE);
    acc_c = 1'b0;

    // Take a request only while idle; its first poll tick goes out now.
    if (rdy_c) begin
      case (in_operation)
        OP_CMD: begin
          acc_c = 1'b1;
          pending_byte_nxt = in_byte_value;
          pending_sel_nxt  = 1'b0;
          phase_nxt        = PH_P0;
        end
        OP_DATA: begin
          acc_c = 1'b1;
          pending_byte_nxt = in_byte_value;
          pending_sel_nxt  = 1'b1;
          phase_nxt        = PH_P0;
        end
        OP_CURSOR: begin
          acc_c = 1'b1;
          pending_byte_nxt = cursor_addr;
          pending_sel_nxt  = 1'b0;
          phase_nxt        = PH_P0;
        end
        OP_CLEAR: begin
          acc_c = 1'b1;
          follow_home_nxt  = 1'b1;
          pending_byte_nxt = CMD_CLEAR;
          pending_sel_nxt  = 1'b0;
          phase_nxt        = PH_P0;
        end
        default: ;
      endcase
    end

    // Hold the last driven levels with E low unless a phase drives them.
    e_c     = 1'b0;
    rs_c    = lvl_rs_r;
    rw_c    = lvl_rw_r;
    bus_c   = lvl_bus_r;
    drive_c = 1'b1;

    case (phase_nxt)
      PH_WAIT: begin
        wait_count_nxt = wait_count_r + 7'd1;
        if (wait_count_nxt >= ((startup_step_r == STEP_SHORT_WAIT) ? SHORT_WAIT_US
                                                                   : LongWait)) begin
          script_adv = 1'b1;
        end
      end
      PH_SU_A, PH_SU_B: begin
        e_c   = (phase_nxt == PH_SU_A);
        rs_c  = 1'b0;
        rw_c  = 1'b0;
        bus_c = (startup_step_r == STEP_NIBBLE_TWO) ? NIB_4BIT : NIB_WAKE;
        if (phase_nxt == PH_SU_A) phase_nxt = PH_SU_B;
        else                      script_adv = 1'b1;
      end
      PH_P0, PH_P1, PH_P2, PH_P3: begin
        e_c     = (phase_nxt == PH_P1) || (phase_nxt == PH_P3);
        rs_c    = 1'b0;
        rw_c    = 1'b1;
        bus_c   = 4'd0;
        drive_c = 1'b0;
        if (phase_nxt == PH_P0) begin
          phase_nxt = PH_P1;
        end else if (phase_nxt == PH_P1) begin
          status_high_nxt = in_bus_in;
          phase_nxt = PH_P2;
        end else if (phase_nxt == PH_P2) begin
          phase_nxt = PH_P3;
        end else begin
          // Busy flag set: poll again
          phase_nxt = status_high_r[3] ? PH_P0 : PH_HI_A;
        end
      end
      PH_HI_A, PH_HI_B, PH_LO_A, PH_LO_B: begin
        e_c   = (phase_nxt == PH_HI_A) || (phase_nxt == PH_LO_A);
        rs_c  = pending_sel_nxt;
        rw_c  = 1'b0;
        bus_c = ((phase_nxt == PH_HI_A) || (phase_nxt == PH_HI_B))
                ? pending_byte_nxt[7:4] : pending_byte_nxt[3:0];
        case (phase_nxt)
          PH_HI_A: phase_nxt = PH_HI_B;
          PH_HI_B: phase_nxt = PH_LO_A;
          PH_LO_A: phase_nxt = PH_LO_B;
          default: begin
            // Byte finished: continue the script, chase a clear with home
            if (startup_step_r < STEP_DONE) begin
              script_adv = 1'b1;
            end else if (follow_home_r) begin
              follow_home_nxt  = 1'b0;
              pending_byte_nxt = CMD_HOME_ADDR;
              pending_sel_nxt  = 1'b0;
              phase_nxt        = PH_P0;
            end else begin
              phase_nxt = PH_IDLE;
            end
          end
        endcase
      end
      default: phase_nxt = PH_IDLE;
    endcase

    // Advance the power-up script and start its next step.
    if (script_adv) begin
      if (startup_step_r < STEP_DONE) startup_step_nxt = startup_step_r + 4'd1;
      case (startup_step_nxt)
        4'd0, 4'd2, 4'd4: begin
          phase_nxt      = PH_WAIT;
          wait_count_nxt = 7'd0;
        end
        4'd1, 4'd3, 4'd5, 4'd6: phase_nxt = PH_SU_A;
        4'd7, 4'd8, 4'd9, 4'd10: begin
          pending_byte_nxt = init_cmd(2'(startup_step_nxt - STEP_FIRST_CMD));
          pending_sel_nxt  = 1'b0;
          phase_nxt        = PH_P0;
        end
        default: begin
          startup_step_nxt = STEP_DONE;
          phase_nxt        = PH_IDLE;
        end
      endcase
    end
  end

  // Advance state only on an accepted tick.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_WAIT;
      wait_count_r   <= 7'd0;
      startup_step_r <= 4'd0;
      pending_byte_r <= 8'd0;
      pending_sel_r  <= 1'b0;
      follow_home_r  <= 1'b0;
      status_high_r  <= 4'd0;
      lvl_rs_r       <= 1'b0;
      lvl_rw_r       <= 1'b0;
      lvl_bus_r      <= 4'd0;
    end else if (accept) begin
      phase_r        <= phase_nxt;
      wait_count_r   <= wait_count_nxt;
      startup_step_r <= startup_step_nxt;
      pending_byte_r <= pending_byte_nxt;
      pending_sel_r  <= pending_sel_nxt;
      follow_home_r  <= follow_home_nxt;
      status_high_r  <= status_high_nxt;
      lvl_rs_r       <= rs_c;
      lvl_rw_r       <= rw_c;
      lvl_bus_r      <= bus_c;
    end
  end

  // Result slot: fill on accept, drop when taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      e_r     <= e_c;
      rs_r    <= rs_c;
      rw_r    <= rw_c;
      bus_r   <= bus_c;
      drive_r <= drive_c;
      rdy_r   <= rdy_c;
      acc_r   <= acc_c;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_pin_enable          = e_r;
  assign out_pin_register_select = rs_r;
  assign out_pin_read_write      = rw_r;
  assign out_bus_out             = bus_r;
  assign out_bus_drive           = drive_r;
  assign out_ready_res           = rdy_r;
  assign out_accepted            = acc_r;

endmodule

// ----- dv/tb_char_lcd_4bit_interface_unit.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the 4-bit character LCD interface unit.
module tb_char_lcd_4bit_interface_unit;
  import lcd4_pkg::*;

  // Pin levels and status flags that one result word carries.
  typedef struct packed {
    logic       en;
    logic       rs;
    logic       rw;
    logic [3:0] bus;
    logic       drive;
    logic       ready_res;
    logic       accepted;
  } lcd_pins_t;

  // Tracks the LCD sequencer tick by tick and checks the pin levels it drives.
  class lcd_pin_checker;
    phase_t     phase;
    logic [6:0] wait_count;
    logic [3:0] step;
    logic [7:0] pend_byte;
    logic       pend_rs;
    logic       home_after;
    logic [3:0] status_hi;
    logic       lvl_rs;
    logic       lvl_rw;
    logic [3:0] lvl_bus;
    logic [6:0] long_wait;

    lcd_pins_t  expected_pins[$];
    int         mismatches;
    int         words;
    int         words_checked;
    int         requests_taken;
    int         busy_polls;

    function void power_on(logic [6:0] wait_us);
      long_wait      = wait_us;
      phase          = PH_WAIT;
      wait_count     = '0;
      step           = '0;
      pend_byte      = '0;
      pend_rs        = 1'b0;
      home_after     = 1'b0;
      status_hi      = '0;
      lvl_rs         = 1'b0;
      lvl_rw         = 1'b0;
      lvl_bus        = '0;
      mismatches     = 0;
      words          = 0;
      words_checked  = 0;
      requests_taken = 0;
      busy_polls     = 0;
    endfunction

    function void load_byte(logic [7:0] b, logic sel);
      pend_byte = b;
      pend_rs   = sel;
      phase     = PH_P0;
    endfunction

    function void run_script();
      case (step)
        4'd0, 4'd2, STEP_SHORT_WAIT: begin
          phase      = PH_WAIT;
          wait_count = '0;
        end
        4'd1, 4'd3, 4'd5, STEP_NIBBLE_TWO: phase = PH_SU_A;
        STEP_FIRST_CMD:     load_byte(CMD_FUNC_SET, 1'b0);
        STEP_FIRST_CMD + 1: load_byte(CMD_DISP_ON, 1'b0);
        STEP_FIRST_CMD + 2: load_byte(CMD_ENTRY, 1'b0);
        STEP_FIRST_CMD + 3: load_byte(CMD_HOME_ADDR, 1'b0);
        default: begin
          step  = STEP_DONE;
          phase = PH_IDLE;
        end
      endcase
    endfunction

    function void script_next();
      if (step < STEP_DONE) step++;
      run_script();
    endfunction

    function void byte_done();
      if (step < STEP_DONE) begin
        script_next();
      end else if (home_after) begin
        home_after = 1'b0;
        load_byte(CMD_HOME_ADDR, 1'b0);
      end else begin
        phase = PH_IDLE;
      end
    endfunction

    // Advance one microsecond tick and queue the pin levels it must produce.
    function void note_word(logic [2:0] op, logic [7:0] bval, logic [5:0] col, logic row,
                            logic [3:0] bus_in);
      lcd_pins_t  p;
      logic [6:0] target;
      p           = '0;
      p.drive     = 1'b1;
      p.ready_res = (phase == PH_IDLE);
      if (p.ready_res && op >= OP_CMD && op <= OP_CLEAR) begin
        p.accepted = 1'b1;
        requests_taken++;
        case (op)
          OP_CMD:    load_byte(bval, 1'b0);
          OP_DATA:   load_byte(bval, 1'b1);
          OP_CURSOR: load_byte(CMD_HOME_ADDR | ((row ? ROW_OFFSET : 8'h00) + {2'b00, col}),
                               1'b0);
          default: begin
            home_after = 1'b1;
            load_byte(CMD_CLEAR, 1'b0);
          end
        endcase
      end

      // Held levels unless this tick drives the lines.
      p.rs  = lvl_rs;
      p.rw  = lvl_rw;
      p.bus = lvl_bus;

      case (phase)
        PH_WAIT: begin
          target = (step == STEP_SHORT_WAIT) ? SHORT_WAIT_US : long_wait;
          wait_count++;
          if (wait_count >= target) script_next();
        end
        PH_SU_A, PH_SU_B: begin
          p.en  = (phase == PH_SU_A);
          p.rs  = 1'b0;
          p.rw  = 1'b0;
          p.bus = (step == STEP_NIBBLE_TWO) ? NIB_4BIT : NIB_WAKE;
          if (phase == PH_SU_A) phase = PH_SU_B;
          else script_next();
        end
        PH_P0, PH_P1, PH_P2, PH_P3: begin
          p.en    = (phase == PH_P1 || phase == PH_P3);
          p.rs    = 1'b0;
          p.rw    = 1'b1;
          p.bus   = '0;
          p.drive = 1'b0;
          case (phase)
            PH_P0: phase = PH_P1;
            PH_P1: begin
              status_hi = bus_in;
              phase     = PH_P2;
            end
            PH_P2: phase = PH_P3;
            default: begin
              if (status_hi[3]) begin
                phase = PH_P0;
                busy_polls++;
              end else begin
                phase = PH_HI_A;
              end
            end
          endcase
        end
        PH_HI_A, PH_HI_B, PH_LO_A, PH_LO_B: begin
          p.en  = (phase == PH_HI_A || phase == PH_LO_A);
          p.rs  = pend_rs;
          p.rw  = 1'b0;
          p.bus = (phase == PH_HI_A || phase == PH_HI_B) ? pend_byte[7:4] : pend_byte[3:0];
          if (phase == PH_LO_B) byte_done();
          else phase = phase_t'(phase + 1);
        end
        default: phase = PH_IDLE;
      endcase

      lvl_rs  = p.rs;
      lvl_rw  = p.rw;
      lvl_bus = p.bus;
      expected_pins.push_back(p);
      words++;
    endfunction

    task report_mismatch(string what);
      mismatches++;
      $display("MISMATCH at word %0d: %s", words_checked, what);
    endtask

    task compare_field(string name, logic [3:0] got, logic [3:0] want);
      if (got !== want) report_mismatch($sformatf("%s got %h want %h", name, got, want));
    endtask

    task check_word(lcd_pins_t got);
      lcd_pins_t want;
      if (expected_pins.size() == 0) begin
        report_mismatch("result word with nothing expected");
        return;
      end
      want = expected_pins.pop_front();
      compare_field("E", 4'(got.en), 4'(want.en));
      compare_field("RS", 4'(got.rs), 4'(want.rs));
      compare_field("RW", 4'(got.rw), 4'(want.rw));
      compare_field("bus_out", got.bus, want.bus);
      compare_field("bus_drive", 4'(got.drive), 4'(want.drive));
      compare_field("ready_res", 4'(got.ready_res), 4'(want.ready_res));
      compare_field("accepted", 4'(got.accepted), 4'(want.accepted));
      words_checked++;
    endtask
  endclass

  localparam int unsigned LONG_WAIT       = 100;
  localparam int          CYCLE_LIMIT     = 400000;
  localparam int          RANDOM_WORDS    = 1200;
  localparam int          HOLD_OFF_CYCLES = 300;

  logic       clk           = 1'b0;
  logic       rst_n         = 1'b0;
  logic       in_valid      = 1'b0;
  logic       in_ready;
  logic [2:0] in_operation  = OP_TICK;
  logic [7:0] in_byte_value = '0;
  logic [5:0] in_column     = '0;
  logic       in_row        = 1'b0;
  logic [3:0] in_bus_in     = '0;
  logic       out_valid;
  logic       out_ready     = 1'b0;
  logic       out_pin_enable;
  logic       out_pin_register_select;
  logic       out_pin_read_write;
  logic [3:0] out_bus_out;
  logic       out_bus_drive;
  logic       out_ready_res;
  logic       out_accepted;

  lcd_pins_t  seen_pins;

  // Knobs the stimulus and the output-ready process share.
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int busy_pct      = 25;
  int hold_off_left = 0;
  int cycle_count   = 0;

  lcd_pin_checker lcd_track = new();

  char_lcd_4bit_interface_unit #(
    .LONG_WAIT_US(LONG_WAIT)
  ) i_dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_operation           (in_operation),
    .in_byte_value          (in_byte_value),
    .in_column              (in_column),
    .in_row                 (in_row),
    .in_bus_in              (in_bus_in),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_pin_enable         (out_pin_enable),
    .out_pin_register_select(out_pin_register_select),
    .out_pin_read_write     (out_pin_read_write),
    .out_bus_out            (out_bus_out),
    .out_bus_drive          (out_bus_drive),
    .out_ready_res          (out_ready_res),
    .out_accepted           (out_accepted)
  );

  assign seen_pins = {out_pin_enable, out_pin_register_select, out_pin_read_write,
                      out_bus_out, out_bus_drive, out_ready_res, out_accepted};

  initial begin
    forever #5 clk = ~clk;
  end

  // Bound the run; a hung handshake ends here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Note each accepted input word, then check each accepted result word.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      lcd_track.note_word(in_operation, in_byte_value, in_column, in_row, in_bus_in);
    if (rst_n && out_valid && out_ready)
      lcd_track.check_word(seen_pins);
  end

  // Drive out_ready: honor a pending hold-off first, else stall at random.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_off_left > 0) begin
        hold_off_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Sample DB7..DB4 as the display would answer; DB7 set means busy.
  function automatic logic [3:0] status_nibble();
    logic busy;
    busy = ($urandom_range(99) < busy_pct);
    return {busy, 3'($urandom_range(7))};
  endfunction

  // Offer one word after a random idle gap and hold it until taken.
  task automatic send_word(input logic [2:0] op, input logic [7:0] bval,
                           input logic [5:0] col, input logic row, input logic [3:0] bus);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_operation  <= op;
    in_byte_value <= bval;
    in_column     <= col;
    in_row        <= row;
    in_bus_in     <= bus;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Feed plain ticks until the sequencer is idle, then issue the request.
  task automatic issue_request(input logic [2:0] op, input logic [7:0] bval,
                               input logic [5:0] col, input logic row);
    while (lcd_track.phase != PH_IDLE)
      send_word(OP_TICK, 8'($urandom_range(255)), 6'($urandom_range(63)),
                1'($urandom_range(1)), status_nibble());
    send_word(op, bval, col, row, status_nibble());
  endtask

  // Mostly requests when idle, mostly ticks while busy, with some noise.
  task automatic send_random_word();
    logic [2:0] op;
    logic [5:0] col;
    int         r;
    r = $urandom_range(99);
    if (lcd_track.phase == PH_IDLE) begin
      if (r < 20) begin
        r  = $urandom_range(3);
        op = (r == 0) ? OP_TICK : 3'(OP_CLEAR + r);
      end else begin
        op = 3'(OP_CMD + $urandom_range(3));
      end
    end else if (r < 85) begin
      op = OP_TICK;
    end else begin
      op = 3'($urandom_range(7));
    end
    // Columns past the visible line are legal too, just rarer.
    col = ($urandom_range(99) < 85) ? 6'($urandom_range(39)) : 6'($urandom_range(63));
    send_word(op, 8'($urandom_range(255)), col, 1'($urandom_range(1)), status_nibble());
  endtask

  // Drop valid and hold until every expected word has come back.
  task automatic wait_results_done();
    in_valid <= 1'b0;
    while (lcd_track.expected_pins.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    int         stage;
    int         k;
    int         send_idle_plan[4];
    int         stall_plan[4];
    logic [2:0] spare_op;

    send_idle_plan = '{0, 64, 0, 11};
    stall_plan     = '{0, 0, 64, 11};
    lcd_track.power_on(7'(LONG_WAIT));

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Power-up script: requests arriving now must be ignored.
    busy_pct = 25;
    while (lcd_track.phase != PH_IDLE) send_random_word();

    // Directed requests: byte extremes, cursor corners, clear, unused opcodes.
    busy_pct = 0;
    issue_request(OP_CMD, 8'h00, '0, 1'b0);
    issue_request(OP_CMD, 8'hFF, '0, 1'b0);
    issue_request(OP_DATA, 8'h00, '0, 1'b0);
    issue_request(OP_DATA, 8'hFF, '0, 1'b0);
    issue_request(OP_DATA, 8'hA5, '0, 1'b0);
    issue_request(OP_CURSOR, 8'h00, 6'd0, 1'b0);
    issue_request(OP_CURSOR, 8'h00, 6'd39, 1'b1);
    issue_request(OP_CURSOR, 8'h00, 6'd63, 1'b1);
    issue_request(OP_CURSOR, 8'h00, 6'd63, 1'b0);
    issue_request(OP_CLEAR, 8'h00, '0, 1'b0);
    spare_op = 3'(OP_CLEAR + 1);
    repeat (3) begin
      issue_request(spare_op, 8'h55, 6'd5, 1'b1);
      spare_op++;
    end

    // Requests while a byte is still going out must be dropped.
    issue_request(OP_DATA, 8'h41, 6'd0, 1'b0);
    send_word(OP_CLEAR, 8'h00, '0, 1'b0, status_nibble());
    send_word(OP_CURSOR, 8'h00, 6'd7, 1'b1, status_nibble());

    // Display stuck busy: the poll must keep repeating.
    busy_pct = 100;
    issue_request(OP_CMD, 8'h0F, '0, 1'b0);
    repeat (20) send_word(OP_TICK, 8'h00, '0, 1'b0, status_nibble());
    busy_pct = 0;
    wait_results_done();

    // Random traffic under four idle/stall mixes.
    busy_pct = 25;
    for (stage = 0; stage < 4; stage++) begin
      send_idle_pct = send_idle_plan[stage];
      stall_pct     = stall_plan[stage];
      for (k = 0; k < RANDOM_WORDS / 4; k++) begin
        // Hold the result side off while words keep coming, to fill the block.
        if (stage == 0 && k == 100) hold_off_left = HOLD_OFF_CYCLES;
        send_random_word();
      end
      wait_results_done();
    end

    repeat (8) @(posedge clk);
    if (lcd_track.expected_pins.size() != 0)
      lcd_track.report_mismatch("expected words left over at end of run");

    $display("Checked %0d tick words: %0d requests taken, %0d busy polls repeated.",
             lcd_track.words_checked, lcd_track.requests_taken, lcd_track.busy_polls);
    $display("Covered power-up script, directed requests and four idle/stall mixes");
    $display("(%0d mismatches).", lcd_track.mismatches);
    if (lcd_track.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
